// ----- rtl/kwm_pkg.sv -----
// shared types and constants for the k-way sorted merge
// no dependencies
package kwm_pkg;

    localparam int DATA_W         = 32;
    localparam int LANE_FW        = 3;
    localparam int CFG_W          = 4;
    localparam int MAX_LANES_DEF  = 8;
    localparam int LANE_DEPTH_DEF = 8;
    localparam int MAX_RESULTS    = 64;
    localparam int RES_CW         = $clog2(MAX_RESULTS + 1);

    // one merged result before the last-of-run flag is known
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     ovf;
        logic                     done;
    } res_t;

    // control of the shared minimum unit
    typedef struct packed {
        logic clear;
        logic sample;
    } cmp_ctl_t;

endpackage

// ----- rtl/kwm_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/kwm_min_unit.sv -----
// shared compare unit that tracks the smallest lane head of one scan
// depends on kwm_pkg
module kwm_min_unit #(
    parameter int LW = 3
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  kwm_pkg::cmp_ctl_t                ctl,
    input  logic signed [kwm_pkg::DATA_W-1:0] head,
    input  logic [LW-1:0]                    head_lane,
    output logic                             found,
    output logic signed [kwm_pkg::DATA_W-1:0] best_value,
    output logic [LW-1:0]                    best_lane
);

    logic                              found_reg;
    logic signed [kwm_pkg::DATA_W-1:0] best_value_reg;
    logic [LW-1:0]                     best_lane_reg;

    // strict less-than keeps the lowest lane on ties
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.sample && (!found_reg || head < best_value_reg))
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ctl.clear && ctl.sample && (!found_reg || head < best_value_reg))
        begin
            best_value_reg <= head;
            best_lane_reg  <= head_lane;
        end
    end

    assign found      = found_reg;
    assign best_value = best_value_reg;
    assign best_lane  = best_lane_reg;

endmodule

// ----- rtl/k_way_sorted_merge.sv -----
// k-way sorted merge: one input transaction, then per result a scan of the lane heads
// that stops at an empty lane not yet finished; S_SCAN and S_CMP visit each non-empty
// lane, then S_POP and S_EMIT; the shared compare unit and one ram read port serialise it
// throughput: one item at a time, at most 64 results per item
// reset: async active low, lanes empty, lanes_in_use = 8; queue ram is not cleared
// depends on kwm_pkg, kwm_ram, kwm_min_unit
module k_way_sorted_merge #(
    parameter int MAX_LANES  = kwm_pkg::MAX_LANES_DEF,
    parameter int LANE_DEPTH = kwm_pkg::LANE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [kwm_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [kwm_pkg::LANE_FW-1:0]       lane,
    input  logic                              has_value,
    input  logic signed [kwm_pkg::DATA_W-1:0] element,
    input  logic                              list_end,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [kwm_pkg::DATA_W-1:0] merged_value,
    output logic                              overflow,
    output logic                              merge_done,
    output logic                              last_of_run
);

    localparam int LW  = $clog2(MAX_LANES);
    localparam int NLW = $clog2(MAX_LANES + 1);
    localparam int PW  = $clog2(LANE_DEPTH);
    localparam int SW  = PW + 1;
    localparam int CW  = $clog2(LANE_DEPTH + 1);
    localparam int AW  = $clog2(MAX_LANES * LANE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_ACCEPT, S_SCAN, S_CMP, S_POP, S_EMIT, S_FLUSH
    } state_t;

    state_t                         state_reg;
    logic [kwm_pkg::CFG_W-1:0]      cfg_reg;
    logic [kwm_pkg::LANE_FW-1:0]    lane_reg;
    logic                           hv_reg;
    logic signed [kwm_pkg::DATA_W-1:0] elem_reg;
    logic                           le_reg;
    logic [CW-1:0]                  cnt_reg [MAX_LANES];
    logic [PW-1:0]                  rp_reg  [MAX_LANES];
    logic [MAX_LANES-1:0]           fin_reg;
    logic [NLW-1:0]                 scan_reg;
    logic                           fin_all_reg;
    logic [1:0]                     heads_reg;
    logic                           big_reg;
    logic [kwm_pkg::RES_CW-1:0]     nres_reg;
    logic                           stop_reg;
    kwm_pkg::res_t                  new_reg;
    kwm_pkg::res_t                  pend_reg;
    logic                           pend_v_reg;
    kwm_pkg::res_t                  out_reg;
    logic                           out_last_reg;
    logic                           out_valid_reg;

    logic [NLW-1:0]                 nl;
    logic                           lane_ok;
    logic [LW-1:0]                  lane_idx;
    logic [LW-1:0]                  scan_idx;
    logic [LW-1:0]                  acc_idx;
    logic [CW-1:0]                  cnt_cur;
    logic [PW-1:0]                  rp_cur;
    logic [SW-1:0]                  tsum;
    logic [SW-1:0]                  tail;
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [AW-1:0]                  ram_raddr;
    logic [kwm_pkg::DATA_W-1:0]     ram_rdata;
    logic                           out_free;
    logic                           out_load;
    logic                           drained;
    kwm_pkg::cmp_ctl_t              cmp_ctl;
    logic                           best_found;
    logic signed [kwm_pkg::DATA_W-1:0] best_value;
    logic [LW-1:0]                  best_lane;

    // effective lane count
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            nl = NLW'(1);
        end
        else if (32'(cfg_reg) > MAX_LANES)
        begin
            nl = NLW'(MAX_LANES);
        end
        else
        begin
            nl = NLW'(cfg_reg);
        end
    end

    // lane state lookup
    assign lane_ok  = 32'(lane_reg) < 32'(nl);
    assign lane_idx = LW'(lane_reg);
    assign scan_idx = scan_reg[LW-1:0];
    assign acc_idx  = (state_reg == S_ACCEPT) ? lane_idx : scan_idx;
    assign cnt_cur  = cnt_reg[acc_idx];
    assign rp_cur   = rp_reg[acc_idx];

    // queue addressing, tail wraps with one compare and subtract
    assign tsum = SW'(rp_cur) + SW'(cnt_cur);
    assign tail = (tsum >= SW'(LANE_DEPTH)) ? tsum - SW'(LANE_DEPTH) : tsum;
    assign ram_we = (state_reg == S_ACCEPT) && lane_ok && !fin_reg[lane_idx] && hv_reg
                    && (cnt_cur != CW'(LANE_DEPTH));
    assign ram_waddr = AW'(lane_idx) * AW'(LANE_DEPTH) + AW'(tail[PW-1:0]);
    assign ram_raddr = AW'(scan_idx) * AW'(LANE_DEPTH) + AW'(rp_cur);

    assign out_free = !out_valid_reg || !out_stall;
    assign drained  = fin_all_reg && (heads_reg == 2'd1) && !big_reg;

    // output register loads the pending result
    assign out_load = pend_v_reg && out_free &&
                      ((state_reg == S_EMIT) || (state_reg == S_FLUSH));

    // compare unit control
    always_comb
    begin
        cmp_ctl.clear  = (state_reg == S_ACCEPT) || (state_reg == S_EMIT);
        cmp_ctl.sample = (state_reg == S_CMP);
    end

    kwm_ram #(
        .WIDTH(kwm_pkg::DATA_W),
        .DEPTH(MAX_LANES * LANE_DEPTH)
    ) u_queue_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(elem_reg),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    kwm_min_unit #(
        .LW(LW)
    ) u_min (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (cmp_ctl),
        .head      ($signed(ram_rdata)),
        .head_lane (scan_idx),
        .found     (best_found),
        .best_value(best_value),
        .best_lane (best_lane)
    );

    // sequencer, lane state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_reg       <= kwm_pkg::CFG_W'(8);
            fin_reg       <= '0;
            pend_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            scan_reg      <= '0;
            nres_reg      <= '0;
            stop_reg      <= 1'b0;
            fin_all_reg   <= 1'b1;
            heads_reg     <= '0;
            big_reg       <= 1'b0;
            lane_reg      <= '0;
            hv_reg        <= 1'b0;
            elem_reg      <= '0;
            le_reg        <= 1'b0;
            new_reg       <= '0;
            pend_reg      <= '0;
            out_reg       <= '0;
            out_last_reg  <= 1'b0;
            for (int i = 0; i < MAX_LANES; i++)
            begin
                cnt_reg[i] <= '0;
                rp_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            // output transaction valid flag
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        lane_reg  <= lane;
                        hv_reg    <= has_value;
                        elem_reg  <= element;
                        le_reg    <= list_end;
                        nres_reg  <= '0;
                        state_reg <= S_ACCEPT;
                    end
                end
                S_ACCEPT:
                begin
                    scan_reg    <= '0;
                    fin_all_reg <= 1'b1;
                    heads_reg   <= '0;
                    big_reg     <= 1'b0;
                    state_reg   <= S_SCAN;
                    if (lane_ok && !fin_reg[lane_idx])
                    begin
                        if (hv_reg && cnt_cur == CW'(LANE_DEPTH))
                        begin
                            pend_reg.value <= '0;
                            pend_reg.ovf   <= 1'b1;
                            pend_reg.done  <= 1'b0;
                            pend_v_reg     <= 1'b1;
                            state_reg      <= S_FLUSH;
                        end
                        else
                        begin
                            if (hv_reg)
                            begin
                                cnt_reg[lane_idx] <= cnt_cur + 1'b1;
                            end
                            if (le_reg)
                            begin
                                fin_reg[lane_idx] <= 1'b1;
                            end
                        end
                    end
                end
                S_SCAN:
                begin
                    if (scan_reg == nl)
                    begin
                        if (!best_found)
                        begin
                            // merge ends with nothing waiting
                            new_reg.value <= '0;
                            new_reg.ovf   <= 1'b0;
                            new_reg.done  <= 1'b1;
                            stop_reg      <= 1'b1;
                            fin_reg       <= '0;
                            for (int i = 0; i < MAX_LANES; i++)
                            begin
                                cnt_reg[i] <= '0;
                                rp_reg[i]  <= '0;
                            end
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_POP;
                        end
                    end
                    else if (cnt_cur == '0)
                    begin
                        if (!fin_reg[scan_idx])
                        begin
                            state_reg <= S_FLUSH;
                        end
                        else
                        begin
                            scan_reg <= scan_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        fin_all_reg <= fin_all_reg & fin_reg[scan_idx];
                        if (heads_reg != 2'd2)
                        begin
                            heads_reg <= heads_reg + 1'b1;
                        end
                        big_reg   <= big_reg | (cnt_cur > CW'(1));
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    scan_reg  <= scan_reg + 1'b1;
                    state_reg <= S_SCAN;
                end
                S_POP:
                begin
                    new_reg.value <= best_value;
                    new_reg.ovf   <= 1'b0;
                    new_reg.done  <= drained;
                    stop_reg      <= drained ||
                                     (nres_reg == kwm_pkg::RES_CW'(kwm_pkg::MAX_RESULTS - 1));
                    nres_reg      <= nres_reg + 1'b1;
                    if (drained)
                    begin
                        fin_reg <= '0;
                        for (int i = 0; i < MAX_LANES; i++)
                        begin
                            cnt_reg[i] <= '0;
                            rp_reg[i]  <= '0;
                        end
                    end
                    else
                    begin
                        cnt_reg[best_lane] <= cnt_reg[best_lane] - 1'b1;
                        rp_reg[best_lane]  <= (rp_reg[best_lane] == PW'(LANE_DEPTH - 1))
                                              ? '0 : rp_reg[best_lane] + 1'b1;
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    // hold one result back until the run end is known
                    if (!pend_v_reg || out_free)
                    begin
                        if (pend_v_reg)
                        begin
                            out_reg      <= pend_reg;
                            out_last_reg <= 1'b0;
                        end
                        pend_reg    <= new_reg;
                        pend_v_reg  <= 1'b1;
                        scan_reg    <= '0;
                        fin_all_reg <= 1'b1;
                        heads_reg   <= '0;
                        big_reg     <= 1'b0;
                        state_reg   <= stop_reg ? S_FLUSH : S_SCAN;
                    end
                end
                S_FLUSH:
                begin
                    if (!pend_v_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_reg      <= pend_reg;
                        out_last_reg <= 1'b1;
                        pend_v_reg   <= 1'b0;
                        stop_reg     <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign merged_value = out_reg.value;
    assign overflow     = out_reg.ovf;
    assign merge_done   = out_reg.done;
    assign last_of_run  = out_last_reg;

endmodule

// ----- rtl/kwm_checker.sv -----
// port-level checks of the k-way sorted merge, bound to the top level
// depends on kwm_pkg and k_way_sorted_merge
module kwm_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [kwm_pkg::DATA_W-1:0] merged_value,
    input logic                              overflow,
    input logic                              merge_done,
    input logic                              last_of_run
);

    // one transaction at a time: busy right after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accepted transaction");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(merged_value)
        && $stable(merge_done))
        else $error("stalled result changed");

    // overflow result is alone and carries no element
    a_ovf_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> merged_value == '0 && last_of_run && !merge_done)
        else $error("malformed overflow result");

    // merge completion always ends the run
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && merge_done |-> last_of_run)
        else $error("merge done without last of run");

endmodule

bind k_way_sorted_merge kwm_checker u_kwm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .merged_value(merged_value),
    .overflow    (overflow),
    .merge_done  (merge_done),
    .last_of_run (last_of_run)
);
